### sv/rnjs_pkg.sv
`timescale 1ns / 1ps
package rnjs_pkg;

	// input command codes
	typedef enum logic [1:0] {
		CMD_MSG   = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PORT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JOIN_MODE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SUCC_IP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SUCC_PORT = 3'd5;
	localparam int unsigned CFG_DATA_W = 32;

	// sent headers and received flag bits
	localparam logic [7:0] HDR_JOIN   = 8'hC0;
	localparam logic [7:0] HDR_NOTIFY = 8'hA0;
	localparam logic [7:0] HDR_STAB   = 8'h90;
	localparam int unsigned BIT_JOIN   = 6;
	localparam int unsigned BIT_NOTIFY = 5;
	localparam int unsigned BIT_STAB   = 4;

	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 136;

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [31:0] ip;
		logic [15:0] port;
	} node_t;

	typedef struct packed {
		node_t pred;
		node_t succ;
		logic  alone;
	} ring_state_t;

	typedef struct packed {
		logic [15:0] own_id;
		logic [31:0] own_ip;
		logic [15:0] own_port;
		logic        join_mode;
		logic [31:0] first_succ_ip;
		logic [15:0] first_succ_port;
	} ring_cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  msg_header;
		logic [15:0] msg_id;
		logic [31:0] msg_ip;
		logic [15:0] msg_port;
		logic [15:0] msg_creator;
	} item_t;

	// field order top down is the reverse of the tdata packing
	typedef struct packed {
		logic [15:0] dest_port;
		logic [31:0] dest_ip;
		logic [15:0] out_creator;
		logic [15:0] out_port;
		logic [31:0] out_ip;
		logic [15:0] out_id;
		logic [7:0]  out_header;
	} result_t;

endpackage

### sv/rnjs_step.sv
`timescale 1ns / 1ps
module rnjs_step (
	input  rnjs_pkg::ring_state_t st,
	input  rnjs_pkg::ring_cfg_t   cfg,
	input  rnjs_pkg::item_t       item,
	output rnjs_pkg::ring_state_t nxt,
	output logic                  emit,
	output rnjs_pkg::result_t     res
);

	logic take;
	logic notify_done;

	// join interval (pred, own] with wrap, pred id used even when not valid
	always_comb begin
		if (cfg.own_id < st.pred.id) begin
			take = (item.msg_id > st.pred.id) || (item.msg_id <= cfg.own_id);
		end else begin
			take = (item.msg_id > st.pred.id) && (item.msg_id <= cfg.own_id);
		end
	end

	// next state and result word
	always_comb begin
		nxt         = st;
		emit        = 1'b0;
		res         = '0;
		notify_done = 1'b0;
		case (rnjs_pkg::cmd_t'(item.cmd))
			rnjs_pkg::CMD_START: begin
				nxt.pred = '0;
				nxt.succ = '0;
				if (!cfg.join_mode) begin
					nxt.alone = 1'b1;
				end else begin
					nxt.alone = 1'b0;
					nxt.succ  = '{valid: 1'b1, id: 16'd0, ip: cfg.first_succ_ip,
						port: cfg.first_succ_port};
					emit            = 1'b1;
					res.out_header  = rnjs_pkg::HDR_JOIN;
					res.out_id      = cfg.own_id;
					res.out_ip      = cfg.own_ip;
					res.out_port    = cfg.own_port;
					res.dest_ip     = cfg.first_succ_ip;
					res.dest_port   = cfg.first_succ_port;
				end
			end
			rnjs_pkg::CMD_TICK: begin
				if (st.succ.valid) begin
					emit           = 1'b1;
					res.out_header = rnjs_pkg::HDR_STAB;
					res.out_id     = cfg.own_id;
					res.out_ip     = cfg.own_ip;
					res.out_port   = cfg.own_port;
					res.dest_ip    = st.succ.ip;
					res.dest_port  = st.succ.port;
				end
			end
			rnjs_pkg::CMD_MSG: begin
				if (item.msg_header[rnjs_pkg::BIT_JOIN]) begin
					if (st.alone) begin
						// second member of the ring: sender is both neighbors
						nxt.pred  = '{valid: 1'b1, id: item.msg_id, ip: item.msg_ip,
							port: item.msg_port};
						nxt.succ  = nxt.pred;
						nxt.alone = 1'b0;
					end else if (take) begin
						nxt.pred = '{valid: 1'b1, id: item.msg_id, ip: item.msg_ip,
							port: item.msg_port};
					end else if (st.succ.valid) begin
						// forward header, id, ip and port unchanged around the ring
						emit           = 1'b1;
						res.out_header = item.msg_header;
						res.out_id     = item.msg_id;
						res.out_ip     = item.msg_ip;
						res.out_port   = item.msg_port;
						res.dest_ip    = st.succ.ip;
						res.dest_port  = st.succ.port;
					end
				end else begin
					if (item.msg_header[rnjs_pkg::BIT_NOTIFY]) begin
						nxt.succ.id = item.msg_creator;
						if (cfg.own_id != item.msg_id) begin
							nxt.succ = '{valid: 1'b1, id: item.msg_id, ip: item.msg_ip,
								port: item.msg_port};
							notify_done = 1'b1;
						end
					end
					if (!notify_done && item.msg_header[rnjs_pkg::BIT_STAB]) begin
						if (!st.pred.valid) begin
							nxt.pred = '{valid: 1'b1, id: item.msg_id, ip: item.msg_ip,
								port: item.msg_port};
						end
						// answer with the (possibly new) predecessor
						emit            = 1'b1;
						res.out_header  = rnjs_pkg::HDR_NOTIFY;
						res.out_id      = nxt.pred.id;
						res.out_ip      = nxt.pred.ip;
						res.out_port    = nxt.pred.port;
						res.out_creator = cfg.own_id;
						res.dest_ip     = item.msg_ip;
						res.dest_port   = item.msg_port;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/ring_node_join_stabilize_unit.sv
`timescale 1ns / 1ps
// an accepted word sits in the input register, then its result word in the result register
// throughput: one word per cycle if m_tready keeps up, set by one step pass on the state
// an input word may be taken while the result register still waits for m_tready
// reset: arst_n low clears node state, configuration registers and both valid flags
// to zero at once; no clearing pass is needed
module ring_node_join_stabilize_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata: msg_header[7:0], msg_id[23:8], msg_ip[55:24], msg_port[71:56], msg_creator[87:72]
	input  logic [rnjs_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: cmd[1:0]
	input  logic [1:0]                         s_tuser,
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata: out_header[7:0], out_id[23:8], out_ip[55:24], out_port[71:56],
	// out_creator[87:72], dest_ip[119:88], dest_port[135:120]
	output logic [rnjs_pkg::OUT_DATA_W-1:0]    m_tdata,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rnjs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rnjs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	rnjs_pkg::item_t       item_s1;
	logic                  valid_s1;
	rnjs_pkg::ring_state_t state_q;
	rnjs_pkg::ring_state_t state_nxt;
	rnjs_pkg::ring_cfg_t   cfg_q;
	rnjs_pkg::result_t     res_nxt;
	rnjs_pkg::result_t     res_q;
	logic                  emit;
	logic                  m_valid_q;
	logic                  adv;

	// item moves into the result stage when that stage is free or drains
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rnjs_pkg::REG_OWN_ID:          cfg_q.own_id          <= cfg_wdata[15:0];
				rnjs_pkg::REG_OWN_IP:          cfg_q.own_ip          <= cfg_wdata[31:0];
				rnjs_pkg::REG_OWN_PORT:        cfg_q.own_port        <= cfg_wdata[15:0];
				rnjs_pkg::REG_JOIN_MODE:       cfg_q.join_mode       <= cfg_wdata[0];
				rnjs_pkg::REG_FIRST_SUCC_IP:   cfg_q.first_succ_ip   <= cfg_wdata[31:0];
				rnjs_pkg::REG_FIRST_SUCC_PORT: cfg_q.first_succ_port <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{cmd: s_tuser, msg_header: s_tdata[7:0], msg_id: s_tdata[23:8],
				msg_ip: s_tdata[55:24], msg_port: s_tdata[71:56],
				msg_creator: s_tdata[87:72]};
		end
	end

	rnjs_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	// node state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res_nxt;
		end
	end

`ifndef SYNTH
	// a start in join mode always sends a join (the check covers the header only)
	a_start_join: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.cmd == rnjs_pkg::CMD_START && cfg_q.join_mode
		|=> m_valid_q && res_q.out_header == rnjs_pkg::HDR_JOIN)
		else $error("start in join mode did not send a join");

	// a start in create mode leaves the node alone with no successor
	a_start_alone: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.cmd == rnjs_pkg::CMD_START && !cfg_q.join_mode
		|=> state_q.alone && !state_q.succ.valid && !m_valid_q)
		else $error("start in create mode left a bad state");

	// a held input word is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input word lost");

	// the predecessor is only dropped by a start
	a_pred_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.pred.valid) |-> $past(adv && item_s1.cmd == rnjs_pkg::CMD_START))
		else $error("predecessor cleared without a start");
`endif

endmodule
